// ----- hdl/lzsswvd_pkg.sv -----
// shared constants and types for the lzss word video decoder
`default_nettype none
package lzsswvd_pkg;

	// history window and word format
	localparam int unsigned WINDOW_DEPTH   = 4096;
	localparam int unsigned WORD_W         = 16;
	localparam int unsigned OFFSET_BITS    = 12;
	localparam int unsigned LEN_BITS       = WORD_W - OFFSET_BITS;
	localparam int unsigned MIN_MATCH      = 3;
	localparam int unsigned FLAGS_PER_WORD = 16;
	localparam int unsigned RUN_W          = 5;
	localparam int unsigned FLAG_CNT_W     = 5;

	// frame and clip counters
	localparam int unsigned PIX_CNT_W   = 19;
	localparam int unsigned FRAME_CNT_W = 16;
	localparam logic [PIX_CNT_W-1:0]   FRAME_PIXELS_RST   = 19'd76800;
	localparam logic [FRAME_CNT_W-1:0] FRAMES_IN_CLIP_RST = 16'd1;

	// configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	typedef enum logic {
		REG_FRAME_PIXELS   = 1'b0,
		REG_FRAMES_IN_CLIP = 1'b1
	} cfg_reg_t;

	// one decoded word waiting for the output side
	typedef struct packed {
		logic [WORD_W-1:0] pixel;
		logic              last_of_run;
		logic              frame_end;
		logic              clip_end;
	} out_word_t;

	localparam int unsigned OUT_DEPTH = 2;

endpackage
`default_nettype wire

// ----- hdl/lzss_word_video_decoder.sv -----
// lzss word video decoder: flag/literal/match decode over a 4096-entry history memory
// path: a literal pixel passes the write stage and then the output queue before it is offered;
//   the pixels of a match are first issued as history reads, then take the same path
// flow: a new code word is taken only once the previous one has left the write stage;
//   copying runs at one pixel per cycle while the output queue has room, set by the single read port of the history
// reset: control state clears at once; the history is not swept, a fill mark makes
//   never-written entries read as zero, so words are taken from the first cycle
`default_nettype none
module lzss_word_video_decoder #(
	parameter int unsigned WINDOW_DEPTH = lzsswvd_pkg::WINDOW_DEPTH
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// code_word
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [lzsswvd_pkg::WORD_W-1:0]        s_tdata,
	// pixel
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [lzsswvd_pkg::WORD_W-1:0]        m_tdata,
	// last_of_run
	output logic                                  m_tlast,
	// bit 0 frame_end, bit 1 clip_end
	output logic [1:0]                            m_tuser,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [lzsswvd_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire  [lzsswvd_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [lzsswvd_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                  pready
);
	import lzsswvd_pkg::*;

	localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
	localparam int unsigned FILLW = AW + 1;

	// configuration
	logic [PIX_CNT_W-1:0]   frame_pixels_q;
	logic [FRAME_CNT_W-1:0] frames_in_clip_q;
	logic                   cfg_wr;
	cfg_reg_t               cfg_sel;

	// decoder state
	logic [AW-1:0]          wp_q;
	logic [FILLW-1:0]       fill_q;
	logic [WORD_W-1:0]      flag_bits_q;
	logic [FLAG_CNT_W-1:0]  flags_left_q;
	logic [PIX_CNT_W-1:0]   pix_cnt_q;
	logic [FRAME_CNT_W-1:0] frame_cnt_q;
	logic [RUN_W-1:0]       rem_q;
	logic [AW-1:0]          rd_q;
	logic [WORD_W-1:0]      prev_pix_q;

	// read/write stage
	logic                   valid_s1;
	logic                   lit_s1;
	logic [WORD_W-1:0]      litval_s1;
	logic                   last_s1;
	logic                   fwd_s1;
	logic                   ok_s1;
	logic [WORD_W-1:0]      mem_rd_s1;

	// output queue
	out_word_t              outq_q [OUT_DEPTH];
	logic                   oq_wr_q;
	logic                   oq_rd_q;
	logic [1:0]             oq_cnt_q;

	logic [WORD_W-1:0]      hist_mem [WINDOW_DEPTH];

	logic                   acc;
	logic                   acc_flag;
	logic                   acc_lit;
	logic                   acc_match;
	logic                   pop;
	logic                   issue;
	logic [2:0]             occ;
	logic [WORD_W-1:0]      pix;
	logic [PIX_CNT_W-1:0]   pc_inc;
	logic [FRAME_CNT_W-1:0] fc_inc;
	logic                   fe;
	logic                   ce;
	logic [FILLW-1:0]       wp_inc;
	logic [RUN_W-1:0]       match_len;
	logic [AW-1:0]          match_rd;
	out_word_t              push_word;

	// apb access
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_sel = cfg_reg_t'(paddr[2]);

	always_comb begin
		unique case (cfg_sel)
			REG_FRAME_PIXELS:   prdata = {{(APB_DATA_W-PIX_CNT_W){1'b0}}, frame_pixels_q};
			REG_FRAMES_IN_CLIP: prdata = {{(APB_DATA_W-FRAME_CNT_W){1'b0}}, frames_in_clip_q};
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q   <= FRAME_PIXELS_RST;
			frames_in_clip_q <= FRAMES_IN_CLIP_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_FRAME_PIXELS:   frame_pixels_q   <= pwdata[PIX_CNT_W-1:0];
				REG_FRAMES_IN_CLIP: frames_in_clip_q <= pwdata[FRAME_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input side: a word is taken only once the previous one has fully drained and the output queue is not full
	assign s_tready  = (rem_q == '0) && !valid_s1 && (oq_cnt_q != 2'd2);
	assign acc       = s_tvalid & s_tready;
	assign acc_flag  = acc && (flags_left_q == '0);
	assign acc_lit   = acc && (flags_left_q != '0) && flag_bits_q[WORD_W-1];
	assign acc_match = acc && (flags_left_q != '0) && !flag_bits_q[WORD_W-1];

	assign match_len = RUN_W'(s_tdata[WORD_W-1:OFFSET_BITS]) + RUN_W'(MIN_MATCH);
	assign match_rd  = wp_q - AW'(s_tdata[OFFSET_BITS-1:0]) - AW'(1);

	// copy issue: room must remain for the word in flight plus this one
	assign pop   = m_tvalid & m_tready;
	assign occ   = {1'b0, oq_cnt_q} + {2'b0, valid_s1};
	assign issue = (rem_q != '0) && (occ <= 3'd1 + {2'b0, pop});

	// pixel selection and frame/clip tracking in the write stage
	always_comb begin
		if (lit_s1) begin
			pix = litval_s1;
		end else if (fwd_s1) begin
			pix = prev_pix_q;
		end else if (ok_s1) begin
			pix = mem_rd_s1;
		end else begin
			pix = '0;
		end
	end

	assign pc_inc = pix_cnt_q + PIX_CNT_W'(1);
	assign fc_inc = frame_cnt_q + FRAME_CNT_W'(1);
	assign fe     = (pc_inc == frame_pixels_q);
	assign ce     = fe && (fc_inc >= frames_in_clip_q);
	assign wp_inc = {1'b0, wp_q} + FILLW'(1);

	assign push_word.pixel       = pix;
	assign push_word.last_of_run = last_s1 | ce;
	assign push_word.frame_end   = fe;
	assign push_word.clip_end    = ce;

	// history memory: read-before-write, one port each way
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hist_mem[wp_q] <= pix;
		end
		if (issue) begin
			mem_rd_s1 <= hist_mem[rd_q];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q         <= '0;
			fill_q       <= '0;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			pix_cnt_q    <= '0;
			frame_cnt_q  <= '0;
			rem_q        <= '0;
			valid_s1     <= 1'b0;
		end else begin
			// clip end drops the rest of the match
			valid_s1 <= (issue | acc_lit) & ~(valid_s1 & ce);
			// flag handling on each taken word, cleared at clip end
			if (valid_s1 && ce) begin
				flag_bits_q  <= '0;
				flags_left_q <= '0;
			end else if (acc_flag) begin
				flag_bits_q  <= s_tdata;
				flags_left_q <= FLAG_CNT_W'(FLAGS_PER_WORD);
			end else if (acc) begin
				flag_bits_q  <= {flag_bits_q[WORD_W-2:0], 1'b0};
				flags_left_q <= flags_left_q - FLAG_CNT_W'(1);
			end
			if (valid_s1 && ce) begin
				rem_q <= '0;
			end else if (acc_match) begin
				rem_q <= match_len;
			end else if (issue) begin
				rem_q <= rem_q - RUN_W'(1);
			end
			// pixel write-back and counters, clip end restarts the decoder
			if (valid_s1) begin
				wp_q <= ce ? '0 : wp_inc[AW-1:0];
				if (wp_inc > fill_q) begin
					fill_q <= wp_inc;
				end
				if (fe) begin
					pix_cnt_q   <= '0;
					frame_cnt_q <= ce ? '0 : fc_inc;
				end else begin
					pix_cnt_q <= pc_inc;
				end
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (acc_match) begin
			rd_q <= match_rd;
		end else if (issue) begin
			rd_q <= rd_q + AW'(1);
		end
		if (valid_s1) begin
			prev_pix_q <= pix;
		end
		if (acc_lit) begin
			lit_s1    <= 1'b1;
			litval_s1 <= s_tdata;
			last_s1   <= 1'b1;
			fwd_s1    <= 1'b0;
			ok_s1     <= 1'b0;
		end else if (issue) begin
			lit_s1    <= 1'b0;
			litval_s1 <= s_tdata;
			last_s1   <= (rem_q == RUN_W'(1));
			// offset of one reads the entry being written this cycle
			fwd_s1    <= valid_s1 && (rd_q == wp_q);
			ok_s1     <= ({1'b0, rd_q} < fill_q);
		end
	end

	// output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				oq_wr_q <= ~oq_wr_q;
			end
			if (pop) begin
				oq_rd_q <= ~oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + {1'b0, valid_s1} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			outq_q[oq_wr_q] <= push_word;
		end
	end

	assign m_tvalid = (oq_cnt_q != '0);
	assign m_tdata  = outq_q[oq_rd_q].pixel;
	assign m_tlast  = outq_q[oq_rd_q].last_of_run;
	assign m_tuser  = {outq_q[oq_rd_q].clip_end, outq_q[oq_rd_q].frame_end};

endmodule
`default_nettype wire

// ----- verif/tb_lzss_word_video_decoder.sv -----
// self-checking testbench for the lzss word video decoder: random and directed code words
module tb_lzss_word_video_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import lzsswvd_pkg::*;

	localparam int unsigned STALL_LIMIT  = 3000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned REPORT_LIMIT = 10;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [WORD_W-1:0]     s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// pixel
	logic [WORD_W-1:0]     m_tdata;
	// last_of_run
	logic                  m_tlast;
	// bit 0 frame_end, bit 1 clip_end
	logic [1:0]            m_tuser;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	lzss_word_video_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	// code words waiting to be sent and pixels waiting to be seen
	logic [WORD_W-1:0] word_q [$];
	out_word_t         pixel_exp_q [$];

	// decoder mirror: history, pointers, flags and frame position
	logic [WORD_W-1:0]      win_mem [WINDOW_DEPTH];
	logic [OFFSET_BITS-1:0] win_wr;
	logic [WORD_W-1:0]      flag_reg;
	logic [FLAG_CNT_W-1:0]  flags_pending;
	logic [PIX_CNT_W-1:0]   pix_in_frame;
	logic [FRAME_CNT_W-1:0] frames_done;
	logic [PIX_CNT_W-1:0]   cfg_frame_pixels   = FRAME_PIXELS_RST;
	logic [FRAME_CNT_W-1:0] cfg_frames_in_clip = FRAMES_IN_CLIP_RST;

	// stimulus side view of flag phase and frame position, keeps groups aligned
	int unsigned            gen_flags    = 0;
	logic [WORD_W-1:0]      gen_flag_reg = '0;
	logic [PIX_CNT_W-1:0]   gen_pix      = '0;
	logic [FRAME_CNT_W-1:0] gen_frames   = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        pressure_req  = 1'b0;
	logic        pressure_done = 1'b0;
	int unsigned hold_left     = 0;
	int unsigned idle_run      = 0;

	int unsigned fails           = 0;
	int unsigned words_taken     = 0;
	int unsigned pixels_seen     = 0;
	int unsigned frame_ends_seen = 0;
	int unsigned clip_ends_seen  = 0;
	int unsigned settings_used   = 0;

	task automatic note_mismatch(string what, int unsigned want_v, int unsigned got_v);
		fails++;
		if (fails <= REPORT_LIMIT)
			$display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
	endtask

	// write one pixel into the mirrored history and advance frame and clip counts
	function automatic out_word_t place_pixel(logic [WORD_W-1:0] v);
		out_word_t o;
		o = '0;
		o.pixel = v;
		win_mem[win_wr] = v;
		win_wr = win_wr + 1'b1;
		pix_in_frame = pix_in_frame + 1'b1;
		if (pix_in_frame == cfg_frame_pixels) begin
			o.frame_end = 1'b1;
			pix_in_frame = '0;
			frames_done = frames_done + 1'b1;
			if (frames_done >= cfg_frames_in_clip) begin
				o.clip_end = 1'b1;
				win_wr = '0;
				flags_pending = '0;
				flag_reg = '0;
				frames_done = '0;
			end
		end
		return o;
	endfunction

	// expected pixels for one accepted code word
	function automatic void decode_word(logic [WORD_W-1:0] w);
		out_word_t              o;
		logic [OFFSET_BITS-1:0] rd;
		int unsigned            len;
		logic                   lit;
		if (flags_pending == 0) begin
			flag_reg = w;
			flags_pending = FLAG_CNT_W'(FLAGS_PER_WORD);
			return;
		end
		lit = flag_reg[WORD_W-1];
		flag_reg = flag_reg << 1;
		flags_pending = flags_pending - 1'b1;
		if (lit) begin
			o = place_pixel(w);
			o.last_of_run = 1'b1;
			pixel_exp_q.push_back(o);
		end else begin
			len = w[WORD_W-1:OFFSET_BITS] + MIN_MATCH;
			// the read slot is taken before the write, so offset 4096 sees the old value
			rd = win_wr - w[OFFSET_BITS-1:0] - 1'b1;
			for (int i = 0; i < len; i++) begin
				o = place_pixel(win_mem[rd]);
				rd = rd + 1'b1;
				o.last_of_run = (i == len - 1) || o.clip_end;
				pixel_exp_q.push_back(o);
				if (o.clip_end)
					break;
			end
		end
	endfunction

	// queue a code word and follow where it leaves the flag group and frame
	function automatic void queue_word(logic [WORD_W-1:0] w);
		int unsigned n;
		word_q.push_back(w);
		if (gen_flags == 0) begin
			gen_flag_reg = w;
			gen_flags = FLAGS_PER_WORD;
			return;
		end
		n = gen_flag_reg[WORD_W-1] ? 1 : w[WORD_W-1:OFFSET_BITS] + MIN_MATCH;
		gen_flag_reg = gen_flag_reg << 1;
		gen_flags--;
		for (int i = 0; i < n; i++) begin
			gen_pix = gen_pix + 1'b1;
			if (gen_pix == cfg_frame_pixels) begin
				gen_pix = '0;
				gen_frames = gen_frames + 1'b1;
				if (gen_frames >= cfg_frames_in_clip) begin
					gen_frames = '0;
					gen_flags = 0;
					break;
				end
			end
		end
	endfunction

	// well-formed groups with random content, a tenth of the match words left as pure noise
	task automatic add_random(int unsigned n);
		logic [WORD_W-1:0] w;
		@(negedge clk);
		for (int k = 0; k < n; k++) begin
			w = WORD_W'($urandom_range(16'hFFFF));
			if ($urandom_range(9) != 0 && gen_flags != 0 && !gen_flag_reg[WORD_W-1]) begin
				// mostly short matches close by, some long or far back
				w[WORD_W-1:OFFSET_BITS] = ($urandom_range(3) == 0) ?
					LEN_BITS'($urandom_range(15)) : LEN_BITS'($urandom_range(2));
				case ($urandom_range(3))
					0: begin
						w[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom_range(12'hFFF));
					end
					1: begin
						w[OFFSET_BITS-1:0] = 12'hFFF;
					end
					default: begin
						w[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom_range(31));
					end
				endcase
			end
			queue_word(w);
		end
	endtask

	// register write followed by a read back of the same register
	task automatic apb_write(cfg_reg_t r, logic [APB_DATA_W-1:0] val, logic [APB_DATA_W-1:0] mask);
		logic [APB_DATA_W-1:0] rb;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (r == REG_FRAME_PIXELS)
			cfg_frame_pixels = val[PIX_CNT_W-1:0];
		else
			cfg_frames_in_clip = val[FRAME_CNT_W-1:0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rb = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rb != (val & mask))
			note_mismatch(r == REG_FRAME_PIXELS ? "frame_pixels read" : "frames_in_clip read",
				val & mask, rb);
	endtask

	task automatic configure(int unsigned fp, int unsigned fic);
		apb_write(REG_FRAME_PIXELS, fp, (1 << PIX_CNT_W) - 1);
		apb_write(REG_FRAMES_IN_CLIP, fic, (1 << FRAME_CNT_W) - 1);
		settings_used++;
	endtask

	// wait until every word is taken and every pixel seen, then let the pipe settle
	task automatic drain();
		while (word_q.size() != 0 || pixel_exp_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// code word sender, predicts on each accepted word
	always @(posedge clk or negedge arst_n) begin : tx_side
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			foreach (win_mem[i])
				win_mem[i] = '0;
			win_wr        = '0;
			flag_reg      = '0;
			flags_pending = '0;
			pix_in_frame  = '0;
			frames_done   = '0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_word(word_q.pop_front());
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= word_q[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// pixel receiver and checker
	always @(posedge clk or negedge arst_n) begin : rx_side
		out_word_t want;
		if (!arst_n) begin
			m_tready      <= 1'b0;
			hold_left     <= 0;
			pressure_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				pixels_seen++;
				if (m_tuser[0])
					frame_ends_seen++;
				if (m_tuser[1])
					clip_ends_seen++;
				if (pixel_exp_q.size() == 0) begin
					note_mismatch("unexpected pixel", 0, m_tdata);
				end else begin
					want = pixel_exp_q.pop_front();
					if (m_tdata != want.pixel)
						note_mismatch("pixel", want.pixel, m_tdata);
					if (m_tlast != want.last_of_run)
						note_mismatch("last_of_run", want.last_of_run, m_tlast);
					if (m_tuser[0] != want.frame_end)
						note_mismatch("frame_end", want.frame_end, m_tuser[0]);
					if (m_tuser[1] != want.clip_end)
						note_mismatch("clip_end", want.clip_end, m_tuser[1]);
				end
			end
			// a long hold-off once, so the block fills and stalls its input
			if (hold_left != 0) begin
				m_tready  <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (pressure_req && !pressure_done) begin
				m_tready      <= 1'b0;
				hold_left     <= HOLD_CYCLES;
				pressure_done <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_run <= 0;
		end else if (idle_run >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	// opening group: zero history at max offset, extreme pixels, overlapping copies,
	// a long match running over a frame end into a clip end
	logic [WORD_W-1:0] intro [12] = '{
		16'h6FFF, 16'h0FFF, 16'hFFFF, 16'h0000, 16'hF000,
		16'hA5A5, 16'h1234, 16'h1001, 16'h8000, 16'h0000, 16'h2003, 16'h7FFF
	};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender rarely idle, receiver mostly stalled
		send_idle_pct = 25;
		recv_idle_pct = 80;
		configure(7, 2);
		@(negedge clk);
		foreach (intro[i])
			queue_word(intro[i]);
		drain();

		// every pixel ends a frame and, with zero frames per clip, the clip too
		configure(1, 0);
		add_random(30);
		drain();

		// no frame end ever, counter keeps growing
		configure(0, 16'hFFFF);
		add_random(35);
		drain();

		// the other way round: sender mostly idle
		send_idle_pct = 80;
		recv_idle_pct = 25;
		// frame size below the current count
		configure(gen_pix >> 1, 2);
		add_random(20);
		drain();

		// frame end just ahead of the count, clip restarts there
		configure(gen_pix + 25, 1);
		add_random(20);
		drain();

		configure(13, 3);
		add_random(60);
		drain();

		// no idling from here on
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(307200, 16'hFFFF);
		add_random(20);
		drain();

		configure(gen_pix + 11, 0);
		add_random(20);
		drain();

		configure(23, 5);
		@(negedge clk);
		pressure_req = 1'b1;
		add_random(50);
		drain();

		if (pixel_exp_q.size() != 0)
			note_mismatch("pixels never seen", pixel_exp_q.size(), 0);
		$display("covered %0d code words under %0d register settings, %0d pixels checked",
			words_taken, settings_used, pixels_seen);
		$display("%0d frame ends and %0d clip ends seen, %0d mismatches",
			frame_ends_seen, clip_ends_seen, fails);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
